@@ hw/rtl/chc_pkg.sv @@
`timescale 1ns / 1ps

package chc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = 3'd4;

    // Register reset values
    localparam logic [15:0] SCALE_ONE = 16'd16384;

    // Datapath widths
    localparam int RAW_W  = 16;
    localparam int DIFF_W = 17;
    localparam int PROD_W = 34;
    localparam int CAL_W  = 18;
    localparam int VEC_W  = 21;   // CORDIC x/y, covers gain of about 1.65 on a 19-bit vector
    localparam int HEAD_W = 16;
    localparam int ROUND_Q14 = 8192;

    // atan(2^-i) in turns at 2^32 per turn
    localparam int ATAN_N = 25;
    localparam logic [31:0] ATAN_TURNS32 [ATAN_N] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028
    };

    // Angle table entry rounded half up to abits per turn
    function automatic logic [31:0] chc_atan(input int idx, input int abits);
        logic [32:0] t;
        int          sh;
        int          k;
        sh = 32 - abits;
        k = (idx < ATAN_N - 1) ? idx : ATAN_N - 1;
        t = {1'b0, ATAN_TURNS32[k]};
        t = t + (33'd1 << (sh - 1));
        return t[32:1] >> (sh - 1);
    endfunction

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SAT_Y,
        ST_INIT,
        ST_ITER,
        ST_FINISH
    } chc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mul_x;
        logic mul_y;
        logic sat_y;
        logic init;
        logic iter;
        logic load_out;
    } chc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_step;
    } chc_sts_t;

endpackage

@@ hw/rtl/chc_ctrl.sv @@
`timescale 1ns / 1ps

module chc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output chc_pkg::chc_cmd_t cmd,
    input  chc_pkg::chc_sts_t sts
);
    import chc_pkg::*;

    chc_state_t state_reg;
    chc_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_MUL_X;
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_SAT_Y;
            ST_SAT_Y:  state_next = ST_INIT;
            ST_INIT:   state_next = ST_ITER;
            ST_ITER:   if (sts.last_step) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_MUL_X:  cmd.mul_x = 1'b1;
            ST_MUL_Y:  cmd.mul_y = 1'b1;
            ST_SAT_Y:  cmd.sat_y = 1'b1;
            ST_INIT:   cmd.init = 1'b1;
            ST_ITER:   cmd.iter = 1'b1;
            ST_FINISH: cmd.load_out = out_free;
            default:   cmd = '0;
        endcase
    end

    // Output beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MUL_X))
        else $error("accepted beat did not start the multiply");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");
    a_iter_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER && sts.last_step) |=> (state_reg == ST_FINISH))
        else $error("CORDIC did not finish after last step");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

@@ hw/rtl/chc_dp.sv @@
`timescale 1ns / 1ps

module chc_dp #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  chc_pkg::chc_cmd_t                     cmd,
    output chc_pkg::chc_sts_t                     sts,
    input  logic                                  cfg_we,
    input  logic [chc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [chc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  sample_valid,
    input  logic signed [chc_pkg::RAW_W-1:0]      raw_x,
    input  logic signed [chc_pkg::RAW_W-1:0]      raw_y,
    output logic [chc_pkg::HEAD_W-1:0]            heading,
    output logic signed [chc_pkg::CAL_W-1:0]      calibrated_x,
    output logic signed [chc_pkg::CAL_W-1:0]      calibrated_y,
    output logic                                  used_new_sample
);
    import chc_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    // Configuration registers
    logic signed [RAW_W-1:0] offset_x_reg;
    logic signed [RAW_W-1:0] offset_y_reg;
    logic [RAW_W-1:0]        scale_x_reg;
    logic [RAW_W-1:0]        scale_y_reg;
    logic [HEAD_W-1:0]       declination_reg;

    // Sample and working registers
    logic signed [RAW_W-1:0]   last_x_reg;
    logic signed [RAW_W-1:0]   last_y_reg;
    logic                      fresh_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [CAL_W-1:0]   cal_x_reg;
    logic signed [CAL_W-1:0]   cal_y_reg;
    logic signed [CAL_W-1:0]   cal_sat;
    logic signed [VEC_W-1:0]   x_reg;
    logic signed [VEC_W-1:0]   y_reg;
    logic [ANGLE_BITS-1:0]     z_reg;
    logic                      zero_reg;
    logic [STEP_W-1:0]         step_reg;
    logic signed [VEC_W-1:0]   xs;
    logic signed [VEC_W-1:0]   ys;
    logic [31:0]               atan_full;
    logic [ANGLE_BITS-1:0]     atan_val;
    logic [HEAD_W-1:0]         z16;
    logic [HEAD_W-1:0]         heading_next;

    // Config writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            scale_x_reg <= SCALE_ONE;
            scale_y_reg <= SCALE_ONE;
            declination_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OFFSET_X:    offset_x_reg <= cfg_data;
                REG_OFFSET_Y:    offset_y_reg <= cfg_data;
                REG_SCALE_X:     scale_x_reg <= cfg_data;
                REG_SCALE_Y:     scale_y_reg <= cfg_data;
                REG_DECLINATION: declination_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Cached sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
        end
        else if (cmd.load_in && sample_valid)
        begin
            last_x_reg <= raw_x;
            last_y_reg <= raw_y;
        end
    end

    // Shared multiplier: (sample - offset) * scale, difference sign-extended, scale taken as unsigned
    always_comb
    begin
        if (cmd.mul_x)
            prod_next = PROD_W'(DIFF_W'(last_x_reg) - DIFF_W'(offset_x_reg))
                        * PROD_W'($signed({1'b0, scale_x_reg}));
        else
            prod_next = PROD_W'(DIFF_W'(last_y_reg) - DIFF_W'(offset_y_reg))
                        * PROD_W'($signed({1'b0, scale_y_reg}));
    end

    // Round half up in Q14, saturate to 18 bits
    always_comb
    begin
        logic signed [PROD_W-1:0] q;
        q = (prod_reg + PROD_W'(ROUND_Q14)) >>> 14;
        if (q > PROD_W'((1 << (CAL_W - 1)) - 1))
            cal_sat = CAL_W'((1 << (CAL_W - 1)) - 1);
        else if (q < -PROD_W'(1 << (CAL_W - 1)))
            cal_sat = CAL_W'(-(1 << (CAL_W - 1)));
        else
            cal_sat = q[CAL_W-1:0];
    end

    // CORDIC step terms
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign atan_full = chc_atan(int'(step_reg), ANGLE_BITS);
    assign atan_val = atan_full[ANGLE_BITS-1:0];
    assign sts.last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    // Calibration and vectoring CORDIC
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            fresh_reg <= sample_valid;
        if (cmd.mul_x || cmd.mul_y)
            prod_reg <= prod_next;
        if (cmd.mul_y)
            cal_x_reg <= cal_sat;
        if (cmd.sat_y)
            cal_y_reg <= cal_sat;
        if (cmd.init)
        begin
            zero_reg <= (cal_x_reg == '0) && (cal_y_reg == '0);
            step_reg <= '0;
            if (cal_x_reg < 0)
            begin
                // left half plane: turn by half a turn first
                x_reg <= -VEC_W'(cal_x_reg);
                y_reg <= -VEC_W'(cal_y_reg);
                z_reg <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
            end
            else
            begin
                x_reg <= VEC_W'(cal_x_reg);
                y_reg <= VEC_W'(cal_y_reg);
                z_reg <= '0;
            end
        end
        else if (cmd.iter)
        begin
            step_reg <= step_reg + 1'b1;
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_val;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_val;
            end
        end
    end

    // Angle to 16-bit binary angle
    generate
        if (ANGLE_BITS > HEAD_W)
        begin : g_round
            localparam int SH = ANGLE_BITS - HEAD_W;
            logic [ANGLE_BITS-1:0] z_rnd;
            assign z_rnd = z_reg + (ANGLE_BITS'(1) << (SH - 1));
            assign z16 = z_rnd[ANGLE_BITS-1 -: HEAD_W];
        end
        else if (ANGLE_BITS < HEAD_W)
        begin : g_widen
            assign z16 = {z_reg, {(HEAD_W - ANGLE_BITS){1'b0}}};
        end
        else
        begin : g_same
            assign z16 = HEAD_W'(z_reg);
        end
    endgenerate

    // Zero vector gives declination alone
    assign heading_next = zero_reg ? declination_reg : z16 + declination_reg;

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            heading <= heading_next;
            calibrated_x <= cal_x_reg;
            calibrated_y <= cal_y_reg;
            used_new_sample <= fresh_reg;
        end
    end

endmodule

@@ hw/rtl/compass_heading_calibrated.sv @@
`timescale 1ns / 1ps

// Channel  Handshake                Payload
// in       in_valid / in_ready      sample_valid, raw_x, raw_y
// out      out_valid / out_ready    heading, calibrated_x, calibrated_y, used_new_sample
// cfg      cfg_we (no wait)         cfg_index, cfg_data
//
// One beat at a time: accept, multiply x then y on one shared multiplier,
// saturate, CORDIC setup, CORDIC_STEPS iterations, then output load, which
// waits while a previous result is still held on out.
// The next beat is accepted while a finished result waits on out.
// Reset (rst_n, async): offsets 0, scales 1.0, declination 0, cached sample 0.

module compass_heading_calibrated #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [chc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [chc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  sample_valid,
    input  logic signed [chc_pkg::RAW_W-1:0]      raw_x,
    input  logic signed [chc_pkg::RAW_W-1:0]      raw_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [chc_pkg::HEAD_W-1:0]            heading,
    output logic signed [chc_pkg::CAL_W-1:0]      calibrated_x,
    output logic signed [chc_pkg::CAL_W-1:0]      calibrated_y,
    output logic                                  used_new_sample
);
    import chc_pkg::*;

    chc_cmd_t cmd;
    chc_sts_t sts;

    chc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    chc_dp #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_valid    (sample_valid),
        .raw_x           (raw_x),
        .raw_y           (raw_y),
        .heading         (heading),
        .calibrated_x    (calibrated_x),
        .calibrated_y    (calibrated_y),
        .used_new_sample (used_new_sample)
    );

endmodule
